// ===== rtl/cfvt_pkg.sv =====
package cfvt_pkg;

    // Field widths
    localparam int PANEL_W = 3;
    localparam int COORD_W = 19;
    localparam int ENT_W   = 24;
    localparam int STAT_W  = 2;

    // Datapath widths
    localparam int MAG_W   = COORD_W;            // magnitude of a Q3.16 coordinate, up to 2^18
    localparam int SQ_W    = 2 * COORD_W - 1;    // square of a magnitude, up to 2^36
    localparam int DEN_W   = SQ_W + 1;           // x^2 + y^2
    localparam int PROD_W  = MAG_W + SQ_W - 1;   // |s| * (2^32 + o^2), below 2^55
    localparam int NUM_W   = PROD_W + 2;         // 2 * product + denominator
    localparam int REM_W   = DEN_W + 1;          // doubled denominator and remainder
    localparam int Q_BITS  = ENT_W;              // quotient bits resolved by the divider

    localparam logic [SQ_W-1:0] ONE_Q32 = SQ_W'(64'd1 << 32);

    localparam logic signed [ENT_W-1:0] ONE_Q16 = 24'sh010000;
    localparam logic signed [ENT_W-1:0] ENT_MAX = 24'sh7FFFFF;
    localparam logic signed [ENT_W-1:0] ENT_MIN = 24'sh800000;

    // Matrix entry selectors
    typedef enum logic [2:0] {
        E_ZERO  = 3'd0,
        E_POS   = 3'd1,
        E_NEG   = 3'd2,
        E_A     = 3'd3,
        E_NEG_A = 3'd4,
        E_B     = 3'd5,
        E_NEG_B = 3'd6,
        E_INV   = 3'd7
    } t_ent;

    typedef t_ent [3:0] t_codes;

    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_PAIR = 2'd1,
        ST_ZERO = 2'd2,
        ST_SAT  = 2'd3
    } t_status;

    // Entry selection per (source, destination) panel pair, entries t00 t01 t10 t11
    localparam t_ent PAIR_TABLE [6][6][4] = '{
        '{ '{E_INV, E_INV, E_INV, E_INV},     '{E_POS, E_ZERO, E_NEG_A, E_B},
           '{E_INV, E_INV, E_INV, E_INV},     '{E_POS, E_ZERO, E_A, E_NEG_B},
           '{E_A, E_NEG_B, E_ZERO, E_POS},    '{E_NEG_A, E_B, E_ZERO, E_POS} },
        '{ '{E_POS, E_ZERO, E_A, E_NEG_B},    '{E_INV, E_INV, E_INV, E_INV},
           '{E_POS, E_ZERO, E_NEG_A, E_B},    '{E_INV, E_INV, E_INV, E_INV},
           '{E_ZERO, E_NEG, E_A, E_NEG_B},    '{E_ZERO, E_POS, E_A, E_NEG_B} },
        '{ '{E_INV, E_INV, E_INV, E_INV},     '{E_POS, E_ZERO, E_A, E_NEG_B},
           '{E_INV, E_INV, E_INV, E_INV},     '{E_POS, E_ZERO, E_NEG_A, E_B},
           '{E_NEG_A, E_B, E_ZERO, E_NEG},    '{E_A, E_NEG_B, E_ZERO, E_NEG} },
        '{ '{E_POS, E_ZERO, E_NEG_A, E_B},    '{E_INV, E_INV, E_INV, E_INV},
           '{E_POS, E_ZERO, E_A, E_NEG_B},    '{E_INV, E_INV, E_INV, E_INV},
           '{E_ZERO, E_POS, E_NEG_A, E_B},    '{E_ZERO, E_NEG, E_NEG_A, E_B} },
        '{ '{E_NEG_A, E_B, E_ZERO, E_POS},    '{E_NEG_A, E_B, E_NEG, E_ZERO},
           '{E_NEG_A, E_B, E_ZERO, E_NEG},    '{E_NEG_A, E_B, E_POS, E_ZERO},
           '{E_INV, E_INV, E_INV, E_INV},     '{E_INV, E_INV, E_INV, E_INV} },
        '{ '{E_A, E_NEG_B, E_ZERO, E_POS},    '{E_A, E_NEG_B, E_POS, E_ZERO},
           '{E_A, E_NEG_B, E_ZERO, E_NEG},    '{E_A, E_NEG_B, E_NEG, E_ZERO},
           '{E_INV, E_INV, E_INV, E_INV},     '{E_INV, E_INV, E_INV, E_INV} }
    };

    // Look up the four entry selectors; codes above the south panel are invalid
    function automatic t_codes pair_codes(input logic [PANEL_W-1:0] sp,
                                          input logic [PANEL_W-1:0] dp);
        t_codes codes;
        codes = '{E_INV, E_INV, E_INV, E_INV};
        if (sp <= 3'd5 && dp <= 3'd5) begin
            for (int i = 0; i < 4; i++) begin
                codes[i] = PAIR_TABLE[sp][dp][i];
            end
        end
        return codes;
    endfunction

    // Word carried through the divider stages
    typedef struct packed {
        t_codes             codes;
        logic               inv;
        logic               zero;
        logic               sx;
        logic               sy;
        logic               ovf_a;
        logic               ovf_b;
        logic [REM_W-1:0]   den;
        logic [REM_W-1:0]   rem_a;
        logic [REM_W-1:0]   rem_b;
        logic [Q_BITS-1:0]  lo_a;
        logic [Q_BITS-1:0]  lo_b;
    } t_div_word;

    // Finished result word
    typedef struct packed {
        logic signed [ENT_W-1:0] t00;
        logic signed [ENT_W-1:0] t01;
        logic signed [ENT_W-1:0] t10;
        logic signed [ENT_W-1:0] t11;
        t_status                 status;
    } t_result;

endpackage

// ===== rtl/cfvt_if.sv =====
interface cfvt_in_if;
    import cfvt_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [PANEL_W-1:0]         source_panel;
    logic [PANEL_W-1:0]         dest_panel;
    logic signed [COORD_W-1:0]  x_coord;
    logic signed [COORD_W-1:0]  y_coord;

    modport source (
        output valid, source_panel, dest_panel, x_coord, y_coord,
        input  ready
    );
    modport sink (
        input  valid, source_panel, dest_panel, x_coord, y_coord,
        output ready
    );
endinterface

interface cfvt_out_if;
    import cfvt_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [ENT_W-1:0]    t00;
    logic signed [ENT_W-1:0]    t01;
    logic signed [ENT_W-1:0]    t10;
    logic signed [ENT_W-1:0]    t11;
    logic [STAT_W-1:0]          status;

    modport source (
        output valid, t00, t01, t10, t11, status,
        input  ready
    );
    modport sink (
        input  valid, t00, t01, t10, t11, status,
        output ready
    );
endinterface

// ===== rtl/cfvt_front.sv =====
module cfvt_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [cfvt_pkg::PANEL_W-1:0]       i_source_panel,
    input  logic [cfvt_pkg::PANEL_W-1:0]       i_dest_panel,
    input  logic signed [cfvt_pkg::COORD_W-1:0] i_x_coord,
    input  logic signed [cfvt_pkg::COORD_W-1:0] i_y_coord,
    output logic                               o_valid,
    input  logic                               i_ready,
    output cfvt_pkg::t_div_word                o_word
);
    import cfvt_pkg::*;

    typedef struct packed {
        t_codes             codes;
        logic               inv;
        logic               sx;
        logic               sy;
        logic [MAG_W-1:0]   mx;
        logic [MAG_W-1:0]   my;
        logic [SQ_W-1:0]    xsq;
        logic [SQ_W-1:0]    ysq;
    } t_sq_word;

    typedef struct packed {
        t_codes             codes;
        logic               inv;
        logic               zero;
        logic               sx;
        logic               sy;
        logic [DEN_W-1:0]   den;
        logic [PROD_W-1:0]  pa;
        logic [PROD_W-1:0]  pb;
    } t_prod_word;

    logic               r_v1, r_v2, r_v3;
    t_sq_word           r_s1, n_s1;
    t_prod_word         r_s2, n_s2;
    t_div_word          r_s3, n_s3;
    logic               en1, en2, en3;

    logic [MAG_W-1:0]       mag_x, mag_y;
    logic [2*MAG_W-1:0]     sq_x, sq_y;
    logic [SQ_W-1:0]        fac_a, fac_b;
    logic [MAG_W+SQ_W-1:0]  prod_a, prod_b;
    logic [NUM_W-1:0]       num_a, num_b;
    logic [REM_W-1:0]       dd;

    // Advance a stage when it is empty or its successor advances
    assign en3     = !r_v3 || i_ready;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;

    // Stage 1: pair lookup, magnitudes and squares
    always_comb begin
        mag_x      = i_x_coord[COORD_W-1] ? MAG_W'(-i_x_coord) : MAG_W'(i_x_coord);
        mag_y      = i_y_coord[COORD_W-1] ? MAG_W'(-i_y_coord) : MAG_W'(i_y_coord);
        sq_x       = mag_x * mag_x;
        sq_y       = mag_y * mag_y;
        n_s1.codes = pair_codes(i_source_panel, i_dest_panel);
        n_s1.inv   = (n_s1.codes[0] == E_INV);
        n_s1.sx    = i_x_coord[COORD_W-1];
        n_s1.sy    = i_y_coord[COORD_W-1];
        n_s1.mx    = mag_x;
        n_s1.my    = mag_y;
        n_s1.xsq   = sq_x[SQ_W-1:0];
        n_s1.ysq   = sq_y[SQ_W-1:0];
    end

    // Stage 2: denominator and numerator products
    always_comb begin
        fac_a      = ONE_Q32 + r_s1.xsq;
        fac_b      = ONE_Q32 + r_s1.ysq;
        prod_a     = r_s1.my * fac_a;
        prod_b     = r_s1.mx * fac_b;
        n_s2.codes = r_s1.codes;
        n_s2.inv   = r_s1.inv;
        n_s2.zero  = (r_s1.mx == '0) && (r_s1.my == '0);
        n_s2.sx    = r_s1.sx;
        n_s2.sy    = r_s1.sy;
        n_s2.den   = DEN_W'(r_s1.xsq) + DEN_W'(r_s1.ysq);
        n_s2.pa    = prod_a[PROD_W-1:0];
        n_s2.pb    = prod_b[PROD_W-1:0];
    end

    // Stage 3: add the rounding half, check quotient range, seed the divider
    always_comb begin
        num_a       = NUM_W'({r_s2.pa, 1'b0}) + NUM_W'(r_s2.den);
        num_b       = NUM_W'({r_s2.pb, 1'b0}) + NUM_W'(r_s2.den);
        dd          = {r_s2.den, 1'b0};
        n_s3.codes  = r_s2.codes;
        n_s3.inv    = r_s2.inv;
        n_s3.zero   = r_s2.zero;
        n_s3.sx     = r_s2.sx;
        n_s3.sy     = r_s2.sy;
        n_s3.den    = dd;
        n_s3.ovf_a  = REM_W'(num_a[NUM_W-1:Q_BITS]) >= dd;
        n_s3.ovf_b  = REM_W'(num_b[NUM_W-1:Q_BITS]) >= dd;
        n_s3.rem_a  = REM_W'(num_a[NUM_W-1:Q_BITS]);
        n_s3.rem_b  = REM_W'(num_b[NUM_W-1:Q_BITS]);
        n_s3.lo_a   = num_a[Q_BITS-1:0];
        n_s3.lo_b   = num_b[Q_BITS-1:0];
    end

    // Hold valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
        end
    end

    // Load payload only with a live word
    always_ff @(posedge i_clk) begin
        if (en1 && i_valid) r_s1 <= n_s1;
        if (en2 && r_v1)    r_s2 <= n_s2;
        if (en3 && r_v2)    r_s3 <= n_s3;
    end

    assign o_valid = r_v3;
    assign o_word  = r_s3;

endmodule

// ===== rtl/cfvt_div_step.sv =====
module cfvt_div_step (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  cfvt_pkg::t_div_word i_word,
    output logic                o_valid,
    input  logic                i_ready,
    output cfvt_pkg::t_div_word o_word
);
    import cfvt_pkg::*;

    logic               r_valid;
    t_div_word          r_word, n_word;
    logic               en;
    logic [REM_W:0]     trial_a, trial_b, diff_a, diff_b;
    logic               ge_a, ge_b;

    assign en      = !r_valid || i_ready;
    assign o_ready = en;

    // Resolve one quotient bit of each ratio
    always_comb begin
        trial_a      = {i_word.rem_a, i_word.lo_a[Q_BITS-1]};
        trial_b      = {i_word.rem_b, i_word.lo_b[Q_BITS-1]};
        ge_a         = trial_a >= {1'b0, i_word.den};
        ge_b         = trial_b >= {1'b0, i_word.den};
        diff_a       = trial_a - {1'b0, i_word.den};
        diff_b       = trial_b - {1'b0, i_word.den};
        n_word       = i_word;
        n_word.rem_a = ge_a ? diff_a[REM_W-1:0] : trial_a[REM_W-1:0];
        n_word.rem_b = ge_b ? diff_b[REM_W-1:0] : trial_b[REM_W-1:0];
        n_word.lo_a  = {i_word.lo_a[Q_BITS-2:0], ge_a};
        n_word.lo_b  = {i_word.lo_b[Q_BITS-2:0], ge_b};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && i_valid) r_word <= n_word;
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

`ifndef SYNTHESIS
    // Remainder stays below the divisor while the quotient is in range and the norm is nonzero
    a_rem_a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_word.ovf_a && !r_word.zero |-> r_word.rem_a < r_word.den)
        else $error("remainder a not below divisor");

    a_rem_b_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_word.ovf_b && !r_word.zero |-> r_word.rem_b < r_word.den)
        else $error("remainder b not below divisor");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_valid)
        else $error("stage holds a word after reset");
`endif

endmodule

// ===== rtl/cfvt_back.sv =====
module cfvt_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  cfvt_pkg::t_div_word i_word,
    output logic                o_valid,
    input  logic                i_ready,
    output cfvt_pkg::t_result   o_res
);
    import cfvt_pkg::*;

    typedef struct packed {
        logic                    sat;
        logic signed [ENT_W-1:0] val;
    } t_ent_val;

    localparam logic [Q_BITS-1:0] POS_LIM = Q_BITS'(ENT_MAX);

    logic               r_valid;
    t_result            r_res, n_res;
    logic               en;
    t_ent_val           ev [4];
    logic               any_sat;

    // Pick, sign and clip one matrix entry
    function automatic t_ent_val entry_val(input t_ent code,
                                           input logic [Q_BITS-1:0] q_a,
                                           input logic [Q_BITS-1:0] q_b,
                                           input logic ovf_a, input logic ovf_b,
                                           input logic neg_a, input logic neg_b);
        t_ent_val           r;
        logic [Q_BITS-1:0]  q;
        logic               ovf;
        logic               neg;
        logic               use_q;
        r.sat = 1'b0;
        r.val = '0;
        q     = q_a;
        ovf   = ovf_a;
        neg   = neg_a;
        use_q = 1'b0;
        case (code)
            E_POS:   r.val = ONE_Q16;
            E_NEG:   r.val = -ONE_Q16;
            E_A:     use_q = 1'b1;
            E_NEG_A: begin
                use_q = 1'b1;
                neg   = !neg_a;
            end
            E_B: begin
                use_q = 1'b1;
                q     = q_b;
                ovf   = ovf_b;
                neg   = neg_b;
            end
            E_NEG_B: begin
                use_q = 1'b1;
                q     = q_b;
                ovf   = ovf_b;
                neg   = !neg_b;
            end
            default: r.val = '0;
        endcase
        if (use_q) begin
            if (neg) begin
                r.sat = ovf || (q > POS_LIM + 1'b1);
                r.val = r.sat ? ENT_MIN : -$signed(q);
            end else begin
                r.sat = ovf || (q > POS_LIM);
                r.val = r.sat ? ENT_MAX : $signed(q);
            end
        end
        return r;
    endfunction

    assign en      = !r_valid || i_ready;
    assign o_ready = en;

    // Build the result word and its status
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            ev[i] = entry_val(i_word.codes[i], i_word.lo_a, i_word.lo_b,
                              i_word.ovf_a, i_word.ovf_b, i_word.sy, i_word.sx);
        end
        any_sat = ev[0].sat || ev[1].sat || ev[2].sat || ev[3].sat;
        if (i_word.inv || i_word.zero) begin
            n_res.t00    = '0;
            n_res.t01    = '0;
            n_res.t10    = '0;
            n_res.t11    = '0;
            n_res.status = i_word.inv ? ST_PAIR : ST_ZERO;
        end else begin
            n_res.t00    = ev[0].val;
            n_res.t01    = ev[1].val;
            n_res.t10    = ev[2].val;
            n_res.t11    = ev[3].val;
            n_res.status = any_sat ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && i_valid) r_res <= n_res;
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ===== rtl/cube_face_vector_transform.sv =====
// Channel  Dir  Fields                                          Accepted when
// i_in     in   source_panel, dest_panel, x_coord, y_coord      valid && ready
// o_out    out  t00, t01, t10, t11, status                      valid && ready
//
// One word per cycle while o_out accepts, through 3 setup stages
// (squares, products, rounding seed), 24 divide stages resolving one quotient
// bit each for both ratios, and one output register.
// Synchronous active-low reset clears every valid bit; payload is not reset.
// Each stage holds its word while the next one is full, so a stall on o_out
// fills bubbles first and input stays ready until the pipeline is full.
module cube_face_vector_transform (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cfvt_in_if.sink     i_in,
    cfvt_out_if.source  o_out
);
    import cfvt_pkg::*;

    logic       v   [Q_BITS+1];
    logic       rdy [Q_BITS+1];
    t_div_word  w   [Q_BITS+1];
    t_result    res;

    cfvt_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in.valid),
        .o_ready        (i_in.ready),
        .i_source_panel (i_in.source_panel),
        .i_dest_panel   (i_in.dest_panel),
        .i_x_coord      (i_in.x_coord),
        .i_y_coord      (i_in.y_coord),
        .o_valid        (v[0]),
        .i_ready        (rdy[0]),
        .o_word         (w[0])
    );

    // Chain the divide stages
    for (genvar k = 0; k < Q_BITS; k++) begin : g_div
        cfvt_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (v[k]),
            .o_ready (rdy[k]),
            .i_word  (w[k]),
            .o_valid (v[k+1]),
            .i_ready (rdy[k+1]),
            .o_word  (w[k+1])
        );
    end

    cfvt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v[Q_BITS]),
        .o_ready (rdy[Q_BITS]),
        .i_word  (w[Q_BITS]),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_res   (res)
    );

    assign o_out.t00    = res.t00;
    assign o_out.t01    = res.t01;
    assign o_out.t10    = res.t10;
    assign o_out.t11    = res.t11;
    assign o_out.status = res.status;

`ifndef SYNTHESIS
    a_pair_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.status == ST_PAIR |->
            o_out.t00 == '0 && o_out.t01 == '0 && o_out.t10 == '0 && o_out.t11 == '0)
        else $error("invalid pair with nonzero entries");

    a_norm_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.status == ST_ZERO |->
            o_out.t00 == '0 && o_out.t01 == '0 && o_out.t10 == '0 && o_out.t11 == '0)
        else $error("zero norm with nonzero entries");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output word present after reset");
`endif

endmodule
